/* hdl/wfc_pkg.sv */
package wfc_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int IDX_W = $clog2(MAX_WAYPOINTS);
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
  localparam int CW = 40;   // CORDIC x/y datapath width
  localparam int ZW = 20;   // CORDIC angle width, 2^-16 rad units

  localparam logic signed [15:0] PI_Q12 = 16'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [15:0] CORDIC_GAIN_Q16 = 16'd39797;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_POSE = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [2:0] REG_PATH_LENGTH = 3'd0;
  localparam logic [2:0] REG_ANGULAR_GAIN = 3'd1;
  localparam logic [2:0] REG_LINEAR_GAIN = 3'd2;
  localparam logic [2:0] REG_HEADING_TOL = 3'd3;
  localparam logic [2:0] REG_ARRIVAL_RAD = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POSE_MUL,
    ST_POSE_SUM,
    ST_TICK_RD,
    ST_TICK_DIFF,
    ST_CORDIC_INIT,
    ST_CORDIC_RUN,
    ST_FINISH,
    ST_MAG,
    ST_ERR,
    ST_PROD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic pose_mul;
    logic pose_sum;
    logic tbl_rd;
    logic tick_diff;
    logic cordic_init;
    logic cordic_step;
    logic finish;
    logic mag;
    logic err;
    logic prod;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic is_pose;
  } status_t;

  // Arctangent of 2^-i in units of 2^-16 rad.
  function automatic logic [ZW-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [ZW-1:0] v;
    unique case (i)
      0: v = 20'd51472;
      1: v = 20'd30386;
      2: v = 20'd16055;
      3: v = 20'd8150;
      4: v = 20'd4091;
      5: v = 20'd2047;
      6: v = 20'd1024;
      7: v = 20'd512;
      8: v = 20'd256;
      9: v = 20'd128;
      10: v = 20'd64;
      11: v = 20'd32;
      12: v = 20'd16;
      13: v = 20'd8;
      14: v = 20'd4;
      15: v = 20'd2;
      16: v = 20'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/wfc_ctrl.sv */
module wfc_ctrl
  import wfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_stall_ok,
  input  logic    out_stall,
  input  logic    out_valid,
  input  op_t     in_op,
  input  logic    tick_go,
  input  status_t sts,
  output logic    in_stall,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic accept;

  assign in_stall = (state_r != ST_IDLE) || !in_stall_ok;
  assign accept = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_POSE) state_nxt = ST_POSE_MUL;
          else if (in_op == OP_TICK && tick_go) state_nxt = ST_TICK_RD;
        end
      end
      ST_POSE_MUL:    state_nxt = ST_POSE_SUM;
      ST_POSE_SUM:    state_nxt = ST_CORDIC_INIT;
      ST_TICK_RD:     state_nxt = ST_TICK_DIFF;
      ST_TICK_DIFF:   state_nxt = ST_CORDIC_INIT;
      ST_CORDIC_INIT: state_nxt = ST_CORDIC_RUN;
      ST_CORDIC_RUN:  if (sts.cordic_done) state_nxt = ST_FINISH;
      ST_FINISH:      state_nxt = sts.is_pose ? ST_IDLE : ST_MAG;
      ST_MAG:         state_nxt = ST_ERR;
      ST_ERR:         state_nxt = ST_PROD;
      ST_PROD:        state_nxt = ST_OUT;
      ST_OUT:         if (!out_valid || !out_stall) state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    cmd.capture = accept;
    unique case (state_r)
      ST_POSE_MUL:    cmd.pose_mul = 1'b1;
      ST_POSE_SUM:    cmd.pose_sum = 1'b1;
      ST_TICK_RD:     cmd.tbl_rd = 1'b1;
      ST_TICK_DIFF:   cmd.tick_diff = 1'b1;
      ST_CORDIC_INIT: cmd.cordic_init = 1'b1;
      ST_CORDIC_RUN:  cmd.cordic_step = !sts.cordic_done;
      ST_FINISH:      cmd.finish = 1'b1;
      ST_MAG:         cmd.mag = 1'b1;
      ST_ERR:         cmd.err = 1'b1;
      ST_PROD:        cmd.prod = 1'b1;
      ST_OUT:         cmd.result = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // The input side takes nothing while an item is in flight.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !accept) else $error("accept while busy");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |=> state_r == ST_IDLE) else $error("result not single");
  a_cordic_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> $past(sts.cordic_done)) else $error("early finish");

endmodule

/* hdl/wfc_datapath.sv */
module wfc_datapath
  import wfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  op_t                in_op,
  input  logic [5:0]         in_slot,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  input  logic [6:0]         path_length,
  input  logic [9:0]         angular_gain,
  input  logic [9:0]         linear_gain,
  input  logic [13:0]        heading_tolerance,
  input  logic [14:0]        arrival_radius,
  input  logic               out_stall,
  output logic               tick_go,
  output status_t            sts,
  output logic               out_valid,
  output logic [14:0]        out_linear_speed,
  output logic signed [15:0] out_angular_speed,
  output logic [5:0]         out_target_used,
  output logic               out_reached
);

  // Waypoint memories.
  logic signed [15:0] wp_x_mem [MAX_WAYPOINTS];
  logic signed [15:0] wp_y_mem [MAX_WAYPOINTS];
  logic signed [15:0] wp_x_r, wp_y_r;

  logic signed [15:0] pose_x_r, pose_y_r, pose_yaw_r;
  logic [IDX_W:0] target_index_r;
  logic is_pose_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [31:0] p_wz_r, p_xy_r, p_yy_r, p_zz_r;

  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic [STEP_W-1:0] step_r;
  logic zero_r;
  logic signed [15:0] ang_q12_r;
  logic [CW+15:0] mag_r;
  logic [16:0] dist_r;
  logic signed [16:0] err_r;
  logic signed [27:0] ang_prod_r;
  logic [26:0] lin_prod_r;
  logic lin_en_r;
  logic [IDX_W:0] len;

  assign len = (path_length > 7'(MAX_WAYPOINTS)) ? (IDX_W+1)'(MAX_WAYPOINTS)
                                                 : (IDX_W+1)'(path_length);
  assign tick_go = target_index_r < len;
  assign sts.cordic_done = (step_r == STEP_W'(CORDIC_STEPS));
  assign sts.is_pose = is_pose_r;

  always_ff @(posedge clk) begin
    if (cmd.capture && in_op == OP_LOAD && 32'(in_slot) < MAX_WAYPOINTS) begin
      wp_x_mem[in_slot[IDX_W-1:0]] <= in_coord_x;
      wp_y_mem[in_slot[IDX_W-1:0]] <= in_coord_y;
    end
    if (cmd.tbl_rd) begin
      wp_x_r <= wp_x_mem[target_index_r[IDX_W-1:0]];
      wp_y_r <= wp_y_mem[target_index_r[IDX_W-1:0]];
    end
  end

  // Capture of the input word and the quaternion products.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_pose_r <= (in_op == OP_POSE);
      qx_r <= in_quat_x;
      qy_r <= in_quat_y;
      qz_r <= in_quat_z;
      qw_r <= in_quat_w;
    end
    if (cmd.pose_mul) begin
      p_wz_r <= qw_r * qz_r;
      p_xy_r <= qx_r * qy_r;
      p_yy_r <= qy_r * qy_r;
      p_zz_r <= qz_r * qz_r;
    end
  end

  // CORDIC vectoring, one step per cycle.
  logic signed [CW-1:0] num_v, den_v, dx_v, dy_v, xs, ys, ix, iy;
  logic signed [ZW-1:0] iz;
  logic signed [ZW-1:0] zr;
  logic signed [15:0] zq;

  always_comb begin
    num_v = CW'(p_wz_r) + CW'(p_xy_r);
    num_v = num_v <<< 1;
    den_v = (CW'(1) <<< 28) - ((CW'(p_yy_r) + CW'(p_zz_r)) <<< 1);
    dx_v = (CW'(wp_x_r) - CW'(pose_x_r)) <<< 8;
    dy_v = (CW'(wp_y_r) - CW'(pose_y_r)) <<< 8;
    xs = cx_r >>> step_r;
    ys = cy_r >>> step_r;
    ix = cx_r;
    iy = cy_r;
    iz = '0;
    if (cx_r < 0) begin
      if (cy_r >= 0) begin
        ix = cy_r;
        iy = -cx_r;
        iz = HALF_PI_Q16;
      end else begin
        ix = -cy_r;
        iy = cx_r;
        iz = -HALF_PI_Q16;
      end
    end
    zr = (cz_r + ZW'(8)) >>> 4;
    if (zr > ZW'(PI_Q12)) zq = PI_Q12;
    else if (zr < -ZW'(PI_Q12)) zq = -PI_Q12;
    else zq = zr[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.pose_sum) begin
      cx_r <= den_v;
      cy_r <= num_v;
    end
    if (cmd.tick_diff) begin
      cx_r <= dx_v;
      cy_r <= dy_v;
    end
    if (cmd.cordic_init) begin
      zero_r <= (cx_r == 0) && (cy_r == 0);
      cx_r <= ix;
      cy_r <= iy;
      cz_r <= iz;
      step_r <= '0;
    end
    if (cmd.cordic_step) begin
      if (cy_r > 0) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + atan_q16(step_r);
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - atan_q16(step_r);
      end
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.finish) ang_q12_r <= zero_r ? '0 : zq;
    // A tick vector is at most 2^24.5 long, so its grown magnitude fits in 27 bits.
    if (cmd.mag) mag_r <= zero_r ? '0 : (CW+16)'(43'(cx_r[26:0]) * 43'(CORDIC_GAIN_Q16));
  end

  // Error, gains and output rounding.
  logic [CW+15:0] dist_full;
  logic signed [16:0] e0;
  logic [16:0] err_abs;
  logic signed [27:0] ang_rnd;
  logic [26:0] lin_rnd;

  always_comb begin
    dist_full = (mag_r + (CW+16)'(1 << 23)) >> 24;
    e0 = 17'(ang_q12_r) - 17'(pose_yaw_r);
    if (e0 > 17'(PI_Q12)) e0 = e0 - TWO_PI_Q12;
    if (e0 < -17'(PI_Q12)) e0 = e0 + TWO_PI_Q12;
    err_abs = err_r[16] ? 17'(-err_r) : 17'(err_r);
    ang_rnd = (ang_prod_r + 28'sd128) >>> 8;
    lin_rnd = (lin_prod_r + 27'd128) >> 8;
  end

  always_ff @(posedge clk) begin
    if (cmd.mag) dist_r <= '1;
    if (cmd.err) begin
      dist_r <= (dist_full > (CW+16)'(17'h1FFFF)) ? 17'h1FFFF : dist_full[16:0];
      err_r <= e0;
    end
    if (cmd.prod) begin
      ang_prod_r <= err_r * $signed({1'b0, angular_gain});
      lin_prod_r <= dist_r * linear_gain;
      lin_en_r <= err_abs < 17'(heading_tolerance);
    end
  end

  // Pose, target index and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r <= '0;
      pose_y_r <= '0;
      pose_yaw_r <= '0;
      target_index_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture && in_op == OP_POSE) begin
        pose_x_r <= in_coord_x;
        pose_y_r <= in_coord_y;
      end
      if (cmd.finish && is_pose_r) pose_yaw_r <= zero_r ? '0 : zq;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.result) begin
        out_valid <= 1'b1;
        if (dist_r < 17'(arrival_radius)) target_index_r <= target_index_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_target_used <= 6'(target_index_r);
      out_reached <= dist_r < 17'(arrival_radius);
      if (ang_rnd > 28'sd32767) out_angular_speed <= 16'sd32767;
      else if (ang_rnd < -28'sd32768) out_angular_speed <= -16'sd32768;
      else out_angular_speed <= ang_rnd[15:0];
      if (!lin_en_r) out_linear_speed <= '0;
      else if (lin_rnd > 27'd32767) out_linear_speed <= 15'h7FFF;
      else out_linear_speed <= lin_rnd[14:0];
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |-> target_index_r < len) else $error("index past path");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cordic_step |-> step_r < STEP_W'(CORDIC_STEPS)) else $error("step overrun");
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pose_yaw_r <= PI_Q12) && (pose_yaw_r >= -PI_Q12)) else $error("yaw out of range");

endmodule

/* hdl/waypoint_follow_controller.sv */
// Proportional waypoint follower. A load word (op 0) writes one waypoint. A pose
// word (op 1) converts the quaternion to yaw through a 16-step CORDIC. A tick word
// (op 2) computes bearing and distance to the current target with the same CORDIC
// and the two gains, and delivers one result; a tick after the path ends gives no
// result. The shared CORDIC takes one step per cycle, and one word is worked on at
// a time.
module waypoint_follow_controller
  import wfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_slot,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_linear_speed,
  output logic signed [15:0] out_angular_speed,
  output logic [5:0]  out_target_used,
  output logic        out_reached,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0] path_length_r;
  logic [9:0] angular_gain_r, linear_gain_r;
  logic [13:0] heading_tol_r;
  logic [14:0] arrival_rad_r;
  logic [2:0] reg_sel;
  logic tick_go;
  status_t sts;
  cmd_t cmd;

  assign pready = 1'b1;
  assign reg_sel = paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_length_r <= '0;
      angular_gain_r <= 10'd128;
      linear_gain_r <= 10'd128;
      heading_tol_r <= 14'd819;
      arrival_rad_r <= 15'd205;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        REG_PATH_LENGTH:  path_length_r <= pwdata[6:0];
        REG_ANGULAR_GAIN: angular_gain_r <= pwdata[9:0];
        REG_LINEAR_GAIN:  linear_gain_r <= pwdata[9:0];
        REG_HEADING_TOL:  heading_tol_r <= pwdata[13:0];
        REG_ARRIVAL_RAD:  arrival_rad_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_PATH_LENGTH:  prdata = 32'(path_length_r);
      REG_ANGULAR_GAIN: prdata = 32'(angular_gain_r);
      REG_LINEAR_GAIN:  prdata = 32'(linear_gain_r);
      REG_HEADING_TOL:  prdata = 32'(heading_tol_r);
      REG_ARRIVAL_RAD:  prdata = 32'(arrival_rad_r);
      default: prdata = '0;
    endcase
  end

  wfc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall_ok(1'b1),
    .out_stall(out_stall), .out_valid(out_valid), .in_op(op_t'(in_op)),
    .tick_go(tick_go), .sts(sts), .in_stall(in_stall), .cmd(cmd)
  );

  wfc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_op(op_t'(in_op)), .in_slot(in_slot),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z), .in_quat_w(in_quat_w),
    .path_length(path_length_r), .angular_gain(angular_gain_r),
    .linear_gain(linear_gain_r), .heading_tolerance(heading_tol_r),
    .arrival_radius(arrival_rad_r), .out_stall(out_stall), .tick_go(tick_go),
    .sts(sts), .out_valid(out_valid), .out_linear_speed(out_linear_speed),
    .out_angular_speed(out_angular_speed), .out_target_used(out_target_used),
    .out_reached(out_reached)
  );

endmodule

/* verif/waypoint_follow_controller_test.sv */
`timescale 1ns / 1ps

module waypoint_follow_controller_test;
  import wfc_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [14:0] lin;
    logic signed [15:0] ang;
    logic [5:0] tgt;
    logic reached;
  } speed_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = OP_LOAD;
  logic [5:0] in_slot = '0;
  logic signed [15:0] in_coord_x = '0;
  logic signed [15:0] in_coord_y = '0;
  logic signed [15:0] in_quat_x = '0;
  logic signed [15:0] in_quat_y = '0;
  logic signed [15:0] in_quat_z = '0;
  logic signed [15:0] in_quat_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [14:0] out_linear_speed;
  logic signed [15:0] out_angular_speed;
  logic [5:0] out_target_used;
  logic out_reached;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow copy of the block's registers and state.
  int unsigned path_len_q, ang_gain_q, lin_gain_q, head_tol_q, arr_rad_q;
  int wp_x[MAX_WAYPOINTS];
  int wp_y[MAX_WAYPOINTS];
  int robot_x, robot_y, robot_heading;
  int unsigned target_idx;
  longint atan_steps[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2, 1};

  speed_cmd_t pending_cmds[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  longint cycle_count = 0;

  waypoint_follow_controller dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
    mismatches++;
  endtask

  // Compare each result word with the oldest expected command.
  always @(posedge clk) begin
    speed_cmd_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected result word", 0, 1);
      end else begin
        e = pending_cmds.pop_front();
        if (out_linear_speed !== e.lin) report_mismatch("linear_speed", e.lin, out_linear_speed);
        if (out_angular_speed !== e.ang)
          report_mismatch("angular_speed", e.ang, out_angular_speed);
        if (out_target_used !== e.tgt) report_mismatch("target_used", e.tgt, out_target_used);
        if (out_reached !== e.reached) report_mismatch("reached", e.reached, out_reached);
      end
    end
  end

  // Vectoring rotation: angle in Q3.12, gain-compensated magnitude.
  function automatic int vector_angle(input longint vx, input longint vy, output longint mag);
    longint x, y, z, t, xs, ys, a;
    x = vx;
    y = vy;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = 102944;
      end else begin
        t = -y; y = x; x = t; z = -102944;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_steps[i];
      end else begin
        x -= ys; y += xs; z -= atan_steps[i];
      end
    end
    mag = x * 39797;
    a = (z + 8) >>> 4;
    if (a > 12868) a = 12868;
    if (a < -12868) a = -12868;
    return int'(a);
  endfunction

  // Update the shadow state for one accepted word and queue any command.
  task automatic predict_word(input logic [1:0] op, input logic [5:0] slot,
                              input logic signed [15:0] cx, input logic signed [15:0] cy,
                              input logic signed [15:0] qx, input logic signed [15:0] qy,
                              input logic signed [15:0] qz, input logic signed [15:0] qw);
    longint num, den, mag, span, err, ang, lin;
    int unsigned len;
    int bearing;
    speed_cmd_t c;
    case (op)
      OP_LOAD: begin
        wp_x[slot] = cx;
        wp_y[slot] = cy;
      end
      OP_POSE: begin
        num = 2 * (longint'(qw) * qz + longint'(qx) * qy);
        den = (longint'(1) << 28) - 2 * (longint'(qy) * qy + longint'(qz) * qz);
        robot_x = cx;
        robot_y = cy;
        robot_heading = vector_angle(den, num, mag);
      end
      OP_TICK: begin
        len = (path_len_q > MAX_WAYPOINTS) ? MAX_WAYPOINTS : path_len_q;
        if (target_idx < len) begin
          bearing = vector_angle((longint'(wp_x[target_idx]) - robot_x) * 256,
                                 (longint'(wp_y[target_idx]) - robot_y) * 256, mag);
          span = (mag + (longint'(1) << 23)) >>> 24;
          err = longint'(bearing) - robot_heading;
          if (err > 12868) err -= 25736;
          if (err < -12868) err += 25736;
          ang = (err * longint'(ang_gain_q) + 128) >>> 8;
          if (ang > 32767) ang = 32767;
          if (ang < -32768) ang = -32768;
          lin = 0;
          if ((err < 0 ? -err : err) < head_tol_q) begin
            lin = (span * lin_gain_q + 128) >>> 8;
            if (lin > 32767) lin = 32767;
          end
          c.lin = lin[14:0];
          c.ang = ang[15:0];
          c.tgt = target_idx[5:0];
          c.reached = (span < arr_rad_q);
          if (c.reached) target_idx++;
          pending_cmds.push_back(c);
        end
      end
      default: ;
    endcase
  endtask

  // Send one word and wait for it to be taken; then idle at random.
  task automatic send_word(input logic [1:0] op, input logic [5:0] slot,
                           input logic signed [15:0] cx, input logic signed [15:0] cy,
                           input logic signed [15:0] qx, input logic signed [15:0] qy,
                           input logic signed [15:0] qz, input logic signed [15:0] qw);
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_slot <= slot;
    in_coord_x <= cx;
    in_coord_y <= cy;
    in_quat_x <= qx;
    in_quat_y <= qy;
    in_quat_z <= qz;
    in_quat_w <= qw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(op, slot, cx, cy, qx, qy, qz, qw);
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every expected command has come and the block is quiet.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input int unsigned value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PATH_LENGTH: path_len_q = value & 32'h7F;
      REG_ANGULAR_GAIN: ang_gain_q = value & 32'h3FF;
      REG_LINEAR_GAIN: lin_gain_q = value & 32'h3FF;
      REG_HEADING_TOL: head_tol_q = value & 32'h3FFF;
      REG_ARRIVAL_RAD: arr_rad_q = value & 32'h7FFF;
      default: ;
    endcase
  endtask

  task automatic set_all(input int unsigned plen, input int unsigned ag, input int unsigned lg,
                         input int unsigned tol, input int unsigned rad);
    cfg_write(REG_PATH_LENGTH, plen);
    cfg_write(REG_ANGULAR_GAIN, ag);
    cfg_write(REG_LINEAR_GAIN, lg);
    cfg_write(REG_HEADING_TOL, tol);
    cfg_write(REG_ARRIVAL_RAD, rad);
  endtask

  task automatic pose(input int x, input int y, input int qz, input int qw);
    send_word(OP_POSE, 0, x, y, 0, 0, qz, qw);
  endtask

  task automatic tick;
    send_word(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Fill the whole waypoint table so that no tick reads an unwritten entry.
  task automatic test_table_fill;
    for (int i = 0; i < MAX_WAYPOINTS; i++) begin
      case (i)
        0: send_word(OP_LOAD, i, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0);
        1: send_word(OP_LOAD, i, -16'sh8000, -16'sh8000, 0, 0, 0, 0);
        2: send_word(OP_LOAD, i, 0, 0, 0, 0, 0, 0);
        default: send_word(OP_LOAD, i, $urandom, $urandom, 0, 0, 0, 0);
      endcase
    end
  endtask

  // Corner cases: extreme poses, target at the robot, heading off, unknown op.
  task automatic test_directed;
    set_all(64, 128, 128, 819, 0);
    tick();
    pose(-32768, -32768, 0, 16384);
    tick();
    send_word(OP_POSE, 0, 32767, 32767, 16384, 16384, -16384, -16384);
    tick();
    send_word(OP_POSE, 0, 0, 0, -16384, 16384, 16384, 16384);
    pose(0, 0, 16384, 0);
    tick();
    pose(0, 0, 16384, -16384);
    tick();
    send_word(OP_NONE, 63, 16'sh7FFF, -1, -1, -1, -1, -1);
    tick();
    cfg_write(REG_ARRIVAL_RAD, 205);
    // The robot sits on the first target, so the index moves on.
    pose(32767, 32767, 0, 16384);
    tick();
    tick();
    pose(-32768, -32768, 0, 16384);
    tick();
  endtask

  // Register extremes: gains, tolerance, radius, long and finished paths.
  task automatic test_registers;
    set_all(100, 1023, 1023, 12868, 0);
    pose(0, 0, 12000, 8000);
    tick();
    tick();
    set_all(64, 0, 0, 0, 0);
    pose(1000, -1000, -9000, 12000);
    tick();
    set_all(0, 1023, 1023, 12868, 0);
    tick();
    tick();
    set_all(64, 700, 300, 6000, 32767);
    tick();
    cfg_write(REG_ARRIVAL_RAD, 0);
    tick();
  endtask

  // Random words; mostly pose and tick sequences, sometimes parked on target.
  task automatic test_random(input int n_words, input int ip, input int sp);
    int r;
    idle_pct = ip;
    stall_pct = sp;
    set_all(($urandom_range(4) == 0) ? 127 : 64, $urandom_range(1023), $urandom_range(1023),
            $urandom_range(12868), $urandom_range(3) == 0 ? $urandom_range(32767) :
            $urandom_range(300));
    for (int k = 0; k < n_words; k++) begin
      r = $urandom_range(99);
      if (k == n_words / 2) drain();
      if (r < 35) begin
        tick();
      end else if (r < 50 && target_idx < MAX_WAYPOINTS) begin
        send_word(OP_POSE, $urandom, wp_x[target_idx] + $urandom_range(200) - 100,
                  wp_y[target_idx] + $urandom_range(200) - 100, $urandom_range(32768) - 16384,
                  $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                  $urandom_range(32768) - 16384);
      end else if (r < 72) begin
        send_word(OP_POSE, $urandom, $urandom, $urandom, $urandom_range(32768) - 16384,
                  $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                  $urandom_range(32768) - 16384);
      end else if (r < 92) begin
        send_word(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_word(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
    drain();
  endtask

  initial begin
    path_len_q = 0;
    ang_gain_q = 128;
    lin_gain_q = 128;
    head_tol_q = 819;
    arr_rad_q = 205;
    robot_x = 0;
    robot_y = 0;
    robot_heading = 0;
    target_idx = 0;
    foreach (wp_x[i]) begin
      wp_x[i] = 0;
      wp_y[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_directed();
    test_registers();
    test_random(190, 0, 0);
    test_random(180, 78, 0);
    test_random(180, 0, 78);
    test_random(180, 19, 19);
    drain();
    if (pending_cmds.size() != 0) report_mismatch("commands never delivered", 0,
                                                  pending_cmds.size());
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
